/* design/packet_reorder_buffer_defines.svh */
// Assertion macros shared by the packet reorder buffer RTL.
// No dependencies; included by the files that carry assertions.
`ifndef PACKET_REORDER_BUFFER_DEFINES_SVH
`define PACKET_REORDER_BUFFER_DEFINES_SVH

`ifndef SYNTH

// Clocked assertion that is switched off while reset is asserted.
`define PRB_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Clocked assertion that also holds during reset.
`define PRB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`else

`define PRB_ASSERT(lbl, clk, rstn, prop, msg)
`define PRB_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

/* design/prb_pkg.sv */
// Shared types and constants of the packet reorder buffer.
// No dependencies; imported by the packet reorder buffer module.
package prb_pkg;

    // Geometry of the slot store. SLOTS must be a power of two.
    localparam int SLOTS     = 64;
    localparam int SLOT_BITS = $clog2(SLOTS);
    localparam int TAG_BITS  = 16;
    localparam int SEQ_BITS  = 64;
    localparam int WIN_BITS  = 6;
    localparam int CNT_BITS  = 7;

    // Reset value of the reorder window register.
    localparam logic [WIN_BITS-1:0] WIN_RESET = 6'd63;

    // Operation codes of an input transaction.
    localparam logic FUNC_INSERT  = 1'b0;
    localparam logic FUNC_DELIVER = 1'b1;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_STORED    = 3'd0,
        ST_DROPPED   = 3'd1,
        ST_REJECTED  = 3'd2,
        ST_DELIVERED = 3'd3,
        ST_NONE      = 3'd4
    } status_t;

    // Input transaction payload.
    typedef struct packed {
        logic        func;
        logic [63:0] seq;
        logic [15:0] packet_tag;
    } prb_in_t;

    // Result transaction payload.
    typedef struct packed {
        status_t     status;
        logic [63:0] seq_out;
        logic [15:0] tag_out;
        logic        last;
        logic [6:0]  delivered_count;
    } prb_out_t;

endpackage

/* design/packet_reorder_buffer.sv */
// Packet reorder buffer: an insert is captured, then window-checked on the shared 64-bit
// adder; a deliver transaction looks up each waiting packet's slot with a tag RAM read, then
// emits it with a sequence increment on the same adder, or returns a none result when nothing
// is waiting. Valid bits are flip-flops cleared by reset, so no clearing pass is needed.
// Depends on prb_pkg, prb_ram and the assertion macro header.
`include "packet_reorder_buffer_defines.svh"

module packet_reorder_buffer
    import prb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  prb_in_t             in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output prb_out_t            out_data,
    input  logic                cfg_wr_en,
    input  logic [WIN_BITS-1:0] cfg_wr_data
);

    // Sequencer states, one-hot.
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CHECK = 4'b0010,
        S_LOOK  = 4'b0100,
        S_EMIT  = 4'b1000
    } state_t;

    state_t                state_reg, state_next;
    logic [SEQ_BITS-1:0]   seq_reg;
    logic [TAG_BITS-1:0]   tag_reg;
    logic [WIN_BITS-1:0]   window_reg;
    logic [SEQ_BITS-1:0]   next_seq_reg, next_seq_next;
    logic [SLOTS-1:0]      slot_valid_reg, slot_valid_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic                  out_valid_reg;
    prb_out_t              out_data_reg;

    logic                  in_accept;
    logic                  out_free;
    logic                  out_load;
    prb_out_t              out_next;

    logic [SEQ_BITS-1:0]   add_a, add_b;
    logic [SEQ_BITS-1:0]   add_sum;
    logic                  add_carry;

    logic [WIN_BITS-1:0]   win_eff;
    logic [SLOT_BITS-1:0]  cur_slot, nxt_slot, ins_slot;
    logic [CNT_BITS-1:0]   cnt_inc;
    logic                  stale, beyond, emit_last;

    logic                  ram_we, ram_re;
    logic [TAG_BITS-1:0]   ram_rdata;

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;

    assign cur_slot = next_seq_reg[SLOT_BITS-1:0];
    assign nxt_slot = cur_slot + SLOT_BITS'(1);
    assign ins_slot = seq_reg[SLOT_BITS-1:0];
    assign cnt_inc  = cnt_reg + CNT_BITS'(1);

    // Shared adder: seq minus expected number while checking, otherwise increment.
    always_comb
    begin
        if (state_reg == S_CHECK)
        begin
            add_a = seq_reg;
            add_b = ~next_seq_reg;
        end
        else
        begin
            add_a = next_seq_reg;
            add_b = '0;
        end
        {add_carry, add_sum} = {1'b0, add_a} + {1'b0, add_b} + (SEQ_BITS + 1)'(1);
    end

    // Window limited so that no two pending numbers share a slot.
    always_comb
    begin
        if ({1'b0, window_reg} > (WIN_BITS + 1)'(SLOTS - 1))
        begin
            win_eff = WIN_BITS'(SLOTS - 1);
        end
        else
        begin
            win_eff = window_reg;
        end
    end

    // A borrow means the number is below the expected one.
    assign stale  = !add_carry;
    assign beyond = add_sum > SEQ_BITS'(win_eff);

    // The last delivered packet is known by looking one slot ahead.
    assign emit_last = !slot_valid_reg[nxt_slot] || (cnt_inc == CNT_BITS'(SLOTS));

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        next_seq_next   = next_seq_reg;
        slot_valid_next = slot_valid_reg;
        cnt_next        = cnt_reg;
        out_load        = 1'b0;
        out_next        = '0;
        ram_we          = 1'b0;
        ram_re          = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                cnt_next = '0;
                if (in_accept)
                begin
                    if (in_data.func == FUNC_DELIVER)
                    begin
                        state_next = S_LOOK;
                    end
                    else
                    begin
                        state_next = S_CHECK;
                    end
                end
            end

            S_CHECK:
            begin
                if (out_free)
                begin
                    out_load         = 1'b1;
                    out_next.seq_out = seq_reg;
                    out_next.last    = 1'b1;
                    if (stale)
                    begin
                        out_next.status = ST_DROPPED;
                    end
                    else if (beyond)
                    begin
                        out_next.status = ST_REJECTED;
                    end
                    else if (slot_valid_reg[ins_slot])
                    begin
                        out_next.status = ST_DROPPED;
                    end
                    else
                    begin
                        out_next.status           = ST_STORED;
                        slot_valid_next[ins_slot] = 1'b1;
                        ram_we                    = 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end

            S_LOOK:
            begin
                if (slot_valid_reg[cur_slot])
                begin
                    ram_re     = 1'b1;
                    state_next = S_EMIT;
                end
                else if (out_free)
                begin
                    out_load         = 1'b1;
                    out_next.status  = ST_NONE;
                    out_next.seq_out = next_seq_reg;
                    out_next.last    = 1'b1;
                    state_next       = S_IDLE;
                end
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_load         = 1'b1;
                    out_next.status  = ST_DELIVERED;
                    out_next.seq_out = next_seq_reg;
                    out_next.tag_out = 16'(ram_rdata);
                    out_next.last    = emit_last;
                    if (emit_last)
                    begin
                        out_next.delivered_count = 7'(cnt_inc);
                        state_next               = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_LOOK;
                    end
                    slot_valid_next[cur_slot] = 1'b0;
                    next_seq_next             = add_sum;
                    cnt_next                  = cnt_inc;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            next_seq_reg   <= '0;
            slot_valid_reg <= '0;
            cnt_reg        <= '0;
            window_reg     <= WIN_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            next_seq_reg   <= next_seq_next;
            slot_valid_reg <= slot_valid_next;
            cnt_reg        <= cnt_next;
            if (cfg_wr_en)
            begin
                window_reg <= cfg_wr_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: captured input transaction and the result register.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            seq_reg <= in_data.seq;
            tag_reg <= TAG_BITS'(in_data.packet_tag);
        end
        if (out_load)
        begin
            out_data_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Packet handle store, one entry per slot.
    prb_ram #(
        .WIDTH (TAG_BITS),
        .DEPTH (SLOTS)
    ) u_tag_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ins_slot),
        .wr_data (tag_reg),
        .rd_en   (ram_re),
        .rd_addr (cur_slot),
        .rd_data (ram_rdata)
    );

    // The delivery count never passes the slot count.
    `PRB_ASSERT(a_cnt_bound, clk, rst_n, cnt_reg <= CNT_BITS'(SLOTS), "delivery count overflow")

    // A packet is only emitted from a filled slot.
    `PRB_ASSERT(a_emit_filled, clk, rst_n, (state_reg == S_EMIT) |-> slot_valid_reg[cur_slot], "emit from empty slot")

    // Each emitted packet advances the expected number by one.
    `PRB_ASSERT(a_seq_advance, clk, rst_n, (state_reg == S_EMIT && out_free) |=> (next_seq_reg == $past(next_seq_reg) + SEQ_BITS'(1)), "expected number did not advance")

    // The final result of a transaction returns the sequencer to idle.
    `PRB_ASSERT(a_last_idle, clk, rst_n, (out_load && out_next.last) |=> (state_reg == S_IDLE), "sequencer busy after last result")

    // A stored insert leaves its slot filled.
    `PRB_ASSERT(a_store_fills, clk, rst_n, (out_load && out_next.status == ST_STORED) |=> slot_valid_reg[$past(ins_slot)], "stored slot not marked filled")

endmodule

/* design/prb_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; used for the packet handle store.
module prb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; the data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
